FILE: hw/rtl/ptds_pkg.sv
package ptds_pkg;

  // field widths of the stream items
  localparam int unsigned FieldWidth  = 12;
  localparam int unsigned StepWidth   = 16;
  localparam int unsigned TempoWidth  = 14;
  localparam int unsigned SlideWidth  = 5;
  localparam int unsigned TableSteps  = 16;
  localparam int unsigned InDataWidth = 48;
  localparam int unsigned OutDataWidth = 8;

  localparam logic [StepWidth-1:0]  WidthReset = 16'h8000;
  localparam logic [TempoWidth-1:0] TempoReset = 14'd2756;
  localparam logic [15:0]           TempoScale = 16'd44100;

  // effect selectors (bits above the parameter nibble)
  localparam logic [7:0] FxWidthOne = 8'd1;
  localparam logic [7:0] FxWidthTwo = 8'd2;
  localparam logic [7:0] FxSlideUp  = 8'd3;
  localparam logic [7:0] FxSlideDn  = 8'd4;
  localparam logic [7:0] FxTempo    = 8'd15;

  // input command codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DRUM,
    PH_TONE
  } play_phase_e;

  typedef enum logic [1:0] {
    ST_READY,
    ST_DIV_ONE,
    ST_DIV_TWO
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic tick;
    logic start_div;
    logic div_sel;
    logic store_one;
    logic apply;
  } ptds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } ptds_sts_t;

  // click-drum durations, one row per pattern
  localparam logic [3:0] DrumTable [4][TableSteps] = '{
    '{4'd4, 4'd2, 4'd3, 4'd2, 4'd4, 4'd1, 4'd10, 4'd1,
      4'd4, 4'd2, 4'd3, 4'd8, 4'd2, 4'd2, 4'd3,  4'd0},
    '{4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,  4'd3,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd4, 4'd4,  4'd0},
    '{4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,  4'd1,
      4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1,  4'd0},
    '{4'd5, 4'd1, 4'd5, 4'd2, 4'd5, 4'd1, 4'd5,  4'd1,
      4'd5, 4'd1, 4'd5, 4'd1, 4'd5, 4'd3, 4'd5,  4'd0}
  };

  // pulse width for parameter p: 0x8000 * p / 15
  function automatic logic [StepWidth-1:0] width_for(input logic [3:0] p);
    logic [StepWidth-1:0] w;
    begin
      case (p)
        4'd0:    w = 16'd0;
        4'd1:    w = 16'd2184;
        4'd2:    w = 16'd4369;
        4'd3:    w = 16'd6553;
        4'd4:    w = 16'd8738;
        4'd5:    w = 16'd10922;
        4'd6:    w = 16'd13107;
        4'd7:    w = 16'd15291;
        4'd8:    w = 16'd17476;
        4'd9:    w = 16'd19660;
        4'd10:   w = 16'd21845;
        4'd11:   w = 16'd24029;
        4'd12:   w = 16'd26214;
        4'd13:   w = 16'd28398;
        4'd14:   w = 16'd30583;
        default: w = 16'd32768;
      endcase
      return w;
    end
  endfunction

endpackage

FILE: hw/rtl/ptds_div.sv
module ptds_div import ptds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FieldWidth-1:0] divisor_i,
  output logic                  done_o,
  output logic [StepWidth-1:0]  quotient_o
);

  localparam int unsigned CntWidth = $clog2(StepWidth + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [FieldWidth-1:0] rem_q, rem_d;
  logic [StepWidth-1:0]  quo_q, quo_d;
  logic [FieldWidth:0]   trial;
  logic [FieldWidth:0]   diff;

  // one quotient bit per cycle, dividend is all ones
  always_comb begin
    trial  = {rem_q, 1'b1};
    diff   = trial - {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(StepWidth);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[FieldWidth-1:0];
        quo_d = {quo_q[StepWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[FieldWidth-1:0];
        quo_d = {quo_q[StepWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/ptds_ctrl.sv
module ptds_ctrl import ptds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_command_i,
  output logic      in_ready_o,
  input  ptds_sts_t sts_i,
  output ptds_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    unique case (state_q)
      ST_READY: begin
        in_ready_o = sts_i.out_free;
        accept     = in_valid_i && sts_i.out_free;
        if (accept) begin
          if (in_command_i == CmdTick) begin
            cmd_o.tick = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = ST_DIV_ONE;
          end
        end
      end
      ST_DIV_ONE: begin
        if (sts_i.div_done) begin
          cmd_o.store_one = 1'b1;
          cmd_o.start_div = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_DIV_TWO;
        end
      end
      ST_DIV_TWO: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ptds_dp.sv
module ptds_dp import ptds_pkg::*; #(
  parameter int unsigned PERIOD_WIDTH = 12,
  parameter int unsigned DRUM_STEPS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptds_cmd_t             cmd_i,
  output ptds_sts_t             sts_o,
  input  logic [FieldWidth-1:0] note1_period_i,
  input  logic [FieldWidth-1:0] note2_period_i,
  input  logic [FieldWidth-1:0] drum_number_i,
  input  logic [FieldWidth-1:0] effect_code_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  sample_o,
  output logic                  row_last_o,
  output logic                  idle_o
);

  localparam int unsigned PeriodBits = (PERIOD_WIDTH < FieldWidth) ? PERIOD_WIDTH : FieldWidth;
  localparam logic [FieldWidth-1:0] PeriodMask = FieldWidth'((1 << PeriodBits) - 1);
  localparam logic [5:0] LastPos = 6'(DRUM_STEPS - 1);
  localparam logic [5:0] StepLimit = 6'(DRUM_STEPS);

  // captured row
  logic [FieldWidth-1:0] p1_q, p2_q, drum_q, fx_q;
  logic [StepWidth-1:0]  q1_q;

  // player state
  logic [TempoWidth-1:0] tempo_q, tempo_d;
  logic [StepWidth-1:0]  width1_q, width1_d, width2_q, width2_d;
  logic [StepWidth-1:0]  phase1_q, phase1_d, phase2_q, phase2_d;
  logic [StepWidth-1:0]  step1_q, step1_d, step2_q, step2_d;
  logic [SlideWidth-1:0] slide_q, slide_d;
  logic                  second_q, second_d;
  logic [1:0]            pat_q, pat_d;
  logic [3:0]            pos_q, pos_d;
  logic [5:0]            cd_q, cd_d;
  play_phase_e           phase_q, phase_d;
  logic [TempoWidth-1:0] remain_q, remain_d;
  logic                  half_q, half_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic sample_q, sample_d, last_q, last_d, idle_q, idle_d;

  logic [StepWidth-1:0]  quotient;
  logic                  div_done;
  logic [FieldWidth-1:0] divisor;
  logic [7:0]            fx_sel;
  logic [3:0]            fx_par;
  logic [19:0]           tempo_prod;
  logic [1:0]            new_pat;
  logic [5:0]            cd_dec;
  logic [3:0]            pos_inc;
  logic [3:0]            entry_next;
  logic [3:0]            entry_first;
  logic [StepWidth-1:0]  ph1_sum, ph2_sum;
  logic                  drum_sel;

  // shared step divider
  assign divisor = cmd_i.div_sel ? p2_q : p1_q;

  ptds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div || cmd_i.capture),
    .divisor_i  (cmd_i.capture ? (note1_period_i & PeriodMask) : divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // capture the row and the first step
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      p1_q   <= note1_period_i & PeriodMask;
      p2_q   <= note2_period_i & PeriodMask;
      drum_q <= drum_number_i;
      fx_q   <= effect_code_i;
    end
    if (cmd_i.store_one) begin
      q1_q <= quotient;
    end
  end

  // row decode helpers
  assign fx_sel      = fx_q[11:4];
  assign fx_par      = fx_q[3:0];
  assign tempo_prod  = 20'(fx_par) * 20'(TempoScale);
  assign new_pat     = 2'(drum_q - FieldWidth'(1));
  assign drum_sel    = (drum_q >= FieldWidth'(1)) && (drum_q <= FieldWidth'(4));
  assign entry_first = (StepLimit > 6'd0) ? DrumTable[new_pat][0] : 4'd0;

  // drum step helpers
  assign cd_dec     = cd_q - 6'd1;
  assign pos_inc    = (cd_dec == 6'd0) ? pos_q + 4'd1 : pos_q;
  assign entry_next = ({2'b00, pos_inc} < StepLimit) ? DrumTable[pat_q][pos_inc] : 4'd0;
  assign ph1_sum    = phase1_q + step1_q;
  assign ph2_sum    = phase2_q + step2_q;

  // row load and tick update
  always_comb begin
    tempo_d     = tempo_q;
    width1_d    = width1_q;
    width2_d    = width2_q;
    phase1_d    = phase1_q;
    phase2_d    = phase2_q;
    step1_d     = step1_q;
    step2_d     = step2_q;
    slide_d     = slide_q;
    second_d    = second_q;
    pat_d       = pat_q;
    pos_d       = pos_q;
    cd_d        = cd_q;
    phase_d     = phase_q;
    remain_d    = remain_q;
    half_d      = half_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sample_d    = sample_q;
    last_d      = last_q;
    idle_d      = idle_q;

    if (cmd_i.apply) begin
      step1_d  = (p1_q == '0) ? '0 : q1_q;
      step2_d  = (p2_q == '0) ? '0 : quotient;
      second_d = (p2_q != '0);
      slide_d  = '0;
      case (fx_sel)
        FxWidthOne: width1_d = width_for(fx_par);
        FxWidthTwo: width2_d = width_for(fx_par);
        FxSlideUp:  slide_d  = {1'b0, fx_par};
        FxSlideDn:  slide_d  = 5'(6'd32 - {2'b00, fx_par});
        FxTempo:    tempo_d  = tempo_prod[TempoWidth+5:6];
        default:    ;
      endcase
      remain_d = tempo_d;
      half_d   = 1'b0;
      if (drum_sel) begin
        pat_d   = new_pat;
        pos_d   = '0;
        cd_d    = {2'b00, entry_first};
        phase_d = PH_DRUM;
      end else begin
        phase_d = (tempo_d != '0) ? PH_TONE : PH_IDLE;
      end
    end

    if (cmd_i.tick) begin
      out_valid_d = 1'b1;
      sample_d    = 1'b0;
      last_d      = 1'b0;
      idle_d      = 1'b0;
      case (phase_q)
        PH_DRUM: begin
          cd_d  = (cd_dec == 6'd0) ? {entry_next, 2'b00} : cd_dec;
          pos_d = pos_inc;
          sample_d = pos_inc[0];
          if (entry_next == 4'd0 || {2'b00, pos_inc} >= LastPos) begin
            if (remain_q != '0) begin
              phase_d = PH_TONE;
            end else begin
              phase_d = PH_IDLE;
              last_d  = 1'b1;
            end
          end
        end
        PH_TONE: begin
          if (!half_q) begin
            phase1_d = ph1_sum;
            sample_d = ph1_sum > width1_q;
            step1_d  = step1_q + {{(StepWidth-SlideWidth){slide_q[SlideWidth-1]}}, slide_q};
            half_d   = 1'b1;
          end else begin
            if (second_q) begin
              phase2_d = ph2_sum;
              sample_d = ph2_sum > width2_q;
            end else begin
              sample_d = phase1_q > width1_q;
            end
            half_d   = 1'b0;
            remain_d = remain_q - TempoWidth'(1);
            if (remain_d == '0) begin
              phase_d = PH_IDLE;
              last_d  = 1'b1;
            end
          end
        end
        default: begin
          idle_d = 1'b1;
        end
      endcase
    end
  end

  // player state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q     <= TempoReset;
      width1_q    <= WidthReset;
      width2_q    <= WidthReset;
      phase1_q    <= '0;
      phase2_q    <= '0;
      step1_q     <= '0;
      step2_q     <= '0;
      slide_q     <= '0;
      second_q    <= 1'b0;
      pat_q       <= '0;
      pos_q       <= '0;
      cd_q        <= '0;
      phase_q     <= PH_IDLE;
      remain_q    <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tempo_q     <= tempo_d;
      width1_q    <= width1_d;
      width2_q    <= width2_d;
      phase1_q    <= phase1_d;
      phase2_q    <= phase2_d;
      step1_q     <= step1_d;
      step2_q     <= step2_d;
      slide_q     <= slide_d;
      second_q    <= second_d;
      pat_q       <= pat_d;
      pos_q       <= pos_d;
      cd_q        <= cd_d;
      phase_q     <= phase_d;
      remain_q    <= remain_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    last_q   <= last_d;
    idle_q   <= idle_d;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign row_last_o     = last_q;
  assign idle_o         = idle_q;

endmodule

FILE: hw/rtl/two_channel_pulse_tone_drum_synth.sv
// channel   | dir | handshake              | payload
// input     | in  | s_axis_tvalid / tready | tuser: command; tdata: periods, drum, effect
// output    | out | m_axis_tvalid / tready | tdata: sample; tlast: row_last; tuser: idle
//
// a tick transfer puts its result in the output register, and the next
// item is taken while that result waits, as long as the register drains in the same cycle
// a row load runs the shared restoring step divider twice, on the note1 and then the note2
// period, and then applies the row update; no result from a load
// rst_ni clears the player to idle with tempo 2756 and both widths at half scale
// a stall on the output side holds s_axis_tready low only once the output register is full
module two_channel_pulse_tone_drum_synth import ptds_pkg::*; #(
  parameter int unsigned PERIOD_WIDTH = 12,
  parameter int unsigned DRUM_STEPS   = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [11:0] note1_period, [23:12] note2_period, [35:24] drum_number, [47:36] effect_code
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // [0] command
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] sample, [7:1] zero
  output logic [OutDataWidth-1:0] m_axis_tdata,
  // row_last
  output logic                    m_axis_tlast,
  // [0] idle
  output logic                    m_axis_tuser
);

  ptds_cmd_t cmd;
  ptds_sts_t sts;
  logic      sample;

  // handshake sequencer
  ptds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // player datapath
  ptds_dp #(
    .PERIOD_WIDTH (PERIOD_WIDTH),
    .DRUM_STEPS   (DRUM_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .note1_period_i (s_axis_tdata[11:0]),
    .note2_period_i (s_axis_tdata[23:12]),
    .drum_number_i  (s_axis_tdata[35:24]),
    .effect_code_i  (s_axis_tdata[47:36]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .sample_o       (sample),
    .row_last_o     (m_axis_tlast),
    .idle_o         (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OutDataWidth-1){1'b0}}, sample};

endmodule

FILE: test/synth_sample_checker.sv
`timescale 1ns / 1ps

module synth_sample_checker import ptds_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  input  logic                    s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    m_axis_tlast,
  input  logic                    m_axis_tuser,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic idle;
    logic row_last;
    logic sample;
  } sample_t;

  localparam int unsigned MaxReported = 10;

  // click lengths per drum pattern, a zero entry ends the pattern
  localparam logic [3:0] ClickLengths [4][16] = '{
    '{4'd4, 4'd2, 4'd3, 4'd2, 4'd4, 4'd1, 4'd10, 4'd1,
      4'd4, 4'd2, 4'd3, 4'd8, 4'd2, 4'd2, 4'd3,  4'd0},
    '{4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,  4'd3,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd4, 4'd4,  4'd0},
    '{4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,  4'd1,
      4'd2, 4'd1, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1,  4'd0},
    '{4'd5, 4'd1, 4'd5, 4'd2, 4'd5, 4'd1, 4'd5,  4'd1,
      4'd5, 4'd1, 4'd5, 4'd1, 4'd5, 4'd3, 4'd5,  4'd0}
  };

  // predicted player state
  logic [13:0] tempo_len;
  logic [15:0] width_a;
  logic [15:0] width_b;
  logic [15:0] phase_a;
  logic [15:0] phase_b;
  logic [15:0] step_a;
  logic [15:0] step_b;
  logic [4:0]  slide;
  logic        ch2_on;
  logic [1:0]  pattern;
  logic [3:0]  drum_pos;
  logic [5:0]  drum_cnt;
  play_phase_e play;
  logic [13:0] pairs_left;
  logic        odd_half;

  sample_t expected_samples [$];
  sample_t predicted;
  sample_t got;

  function automatic logic [3:0] click_length(input logic [1:0] pat, input logic [3:0] pos);
    return ClickLengths[pat][pos];
  endfunction

  // new row: steps from periods, effect, then drum or tone
  task automatic predict_row_load(input logic [InDataWidth-1:0] d);
    logic [11:0] p1;
    logic [11:0] p2;
    logic [11:0] drum;
    logic [11:0] fx;
    int unsigned prm;
    p1   = d[11:0];
    p2   = d[23:12];
    drum = d[35:24];
    fx   = d[47:36];
    prm  = fx[3:0];
    step_a = (p1 == 0) ? 16'd0 : 16'(32'hffff / p1);
    step_b = (p2 == 0) ? 16'd0 : 16'(32'hffff / p2);
    ch2_on = (p2 != 0);
    slide  = '0;
    case (fx[11:4])
      FxWidthOne: width_a = 16'((32'h8000 * prm) / 15);
      FxWidthTwo: width_b = 16'((32'h8000 * prm) / 15);
      FxSlideUp:  slide = 5'(prm);
      FxSlideDn:  slide = 5'(32 - prm);
      FxTempo:    tempo_len = 14'((prm * 44100) / 64);
      default: ;
    endcase
    pairs_left = tempo_len;
    odd_half   = 1'b0;
    if (drum >= 1 && drum <= 4) begin
      pattern  = 2'(drum - 1);
      drum_pos = '0;
      drum_cnt = {2'b00, click_length(pattern, 4'd0)};
      play     = PH_DRUM;
    end else begin
      play = (pairs_left != 0) ? PH_TONE : PH_IDLE;
    end
  endtask

  // one sample tick
  task automatic predict_tick(output sample_t r);
    r = '0;
    case (play)
      PH_DRUM: begin
        drum_cnt = drum_cnt - 6'd1;
        if (drum_cnt == 0) begin
          drum_pos = drum_pos + 4'd1;
          drum_cnt = {click_length(pattern, drum_pos), 2'b00};
        end
        r.sample = drum_pos[0];
        if (click_length(pattern, drum_pos) == 0 || drum_pos == 4'(TableSteps - 1)) begin
          if (pairs_left != 0) begin
            play = PH_TONE;
          end else begin
            play       = PH_IDLE;
            r.row_last = 1'b1;
          end
        end
      end
      PH_TONE: begin
        if (!odd_half) begin
          phase_a  = phase_a + step_a;
          r.sample = phase_a > width_a;
          step_a   = step_a + {{11{slide[4]}}, slide};
          odd_half = 1'b1;
        end else begin
          if (ch2_on) begin
            phase_b  = phase_b + step_b;
            r.sample = phase_b > width_b;
          end else begin
            r.sample = phase_a > width_a;
          end
          odd_half   = 1'b0;
          pairs_left = pairs_left - 14'd1;
          if (pairs_left == 0) begin
            play       = PH_IDLE;
            r.row_last = 1'b1;
          end
        end
      end
      default: r.idle = 1'b1;
    endcase
  endtask

  task automatic note_mismatch(input string what, input sample_t want, input sample_t seen,
                               input logic [OutDataWidth-1:0] data);
    if (mismatch_count_o < MaxReported) begin
      $display("mismatch (%s) at %0t: expected sample %0b row_last %0b idle %0b, got tdata %h row_last %0b idle %0b",
               what, $realtime, want.sample, want.row_last, want.idle, data,
               seen.row_last, seen.idle);
    end
    mismatch_count_o++;
  endtask

  // predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_len  = 14'd2756;
      width_a    = 16'h8000;
      width_b    = 16'h8000;
      phase_a    = '0;
      phase_b    = '0;
      step_a     = '0;
      step_b     = '0;
      slide      = '0;
      ch2_on     = 1'b0;
      pattern    = '0;
      drum_pos   = '0;
      drum_cnt   = '0;
      play       = PH_IDLE;
      pairs_left = '0;
      odd_half   = 1'b0;
      expected_samples.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CmdLoad) begin
          predict_row_load(s_axis_tdata);
        end else begin
          predict_tick(predicted);
          expected_samples.push_back(predicted);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tlast, m_axis_tdata[0]};
        if (expected_samples.size() == 0) begin
          note_mismatch("nothing expected", '0, got, m_axis_tdata);
        end else begin
          predicted = expected_samples.pop_front();
          if (m_axis_tdata[OutDataWidth-1:1] != '0 || got != predicted) begin
            note_mismatch("field", predicted, got, m_axis_tdata);
          end
        end
      end
      pending_o = expected_samples.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ptds_pkg::*;

  localparam int unsigned ClockPeriod = 10;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 950;
  localparam int unsigned DrainCycles = 64;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    s_axis_tuser = CmdTick;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    m_axis_tuser;

  int unsigned send_idle_pct = 16;
  int unsigned recv_stall_pct = 61;
  int unsigned cycle_count = 0;
  int          mismatch_count;
  int          pending_count;

  two_channel_pulse_tone_drum_synth u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  synth_sample_checker u_sample_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  initial begin
    forever #(ClockPeriod / 2) clk_i = ~clk_i;
  end

  // output side stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // one input transfer, with an optional gap before it
  task automatic send_item(input logic cmd, input logic [InDataWidth-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // a row load followed by ticks carrying don't-care payload
  task automatic play_row(input logic [11:0] p1, input logic [11:0] p2,
                          input logic [11:0] drum, input logic [11:0] fx,
                          input int unsigned ticks);
    send_item(CmdLoad, {fx, drum, p2, p1});
    repeat (ticks) send_item(CmdTick, InDataWidth'({$urandom, $urandom}));
  endtask

  initial begin
    int unsigned stim_count;
    int unsigned ticks;
    int unsigned pick;
    logic [11:0] p1;
    logic [11:0] p2;
    logic [11:0] drum;
    logic [11:0] fx;
    logic [3:0]  prm;

    stim_count = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, period extremes, every effect, zero tempo, unknown codes
    send_item(CmdTick, '0);
    play_row(12'd4095, 12'd4095, 12'd0, 12'h000, 3);
    play_row(12'd1, 12'd0, 12'd0, {FxWidthOne, 4'd15}, 2);
    play_row(12'd0, 12'd1, 12'd0, {FxWidthTwo, 4'd0}, 2);
    play_row(12'd1, 12'd1, 12'd0, {FxSlideUp, 4'd15}, 2);
    play_row(12'd2, 12'd4095, 12'd0, {FxSlideDn, 4'd15}, 2);
    play_row(12'd100, 12'd200, 12'd0, {FxTempo, 4'd0}, 1);
    play_row(12'd5, 12'd0, 12'hfff, 12'hfff, 1);
    // drum row cut off by the next load
    play_row(12'd7, 12'd9, 12'd4, {FxTempo, 4'd15}, 2);

    // random rows
    while (stim_count < RandomItems) begin
      if (stim_count < RandomItems / 3) begin
        send_idle_pct  = 16;
        recv_stall_pct = 61;
      end else if (stim_count < 2 * RandomItems / 3) begin
        send_idle_pct  = 61;
        recv_stall_pct = 16;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      pick = $urandom_range(9);
      p1 = (pick == 0) ? 12'd0 : (pick < 4) ? 12'($urandom_range(32, 1)) : 12'($urandom);
      pick = $urandom_range(9);
      p2 = (pick < 3) ? 12'd0 : (pick < 5) ? 12'($urandom_range(32, 1)) : 12'($urandom);
      pick = $urandom_range(19);
      drum = (pick < 9) ? 12'd0 : (pick < 16) ? 12'($urandom_range(4, 1)) : 12'($urandom);
      prm = 4'($urandom);
      case ($urandom_range(6))
        0:       fx = {FxWidthOne, prm};
        1:       fx = {FxWidthTwo, prm};
        2:       fx = {FxSlideUp, prm};
        3:       fx = {FxSlideDn, prm};
        4:       fx = {FxTempo, prm};
        default: fx = 12'($urandom);
      endcase

      // long rows let a drum pattern run out, half of them with zero tempo
      if ($urandom_range(5) == 0) begin
        ticks = 200 + $urandom_range(15);
        drum  = 12'($urandom_range(4, 1));
        if ($urandom_range(1) == 0) fx = {FxTempo, 4'd0};
      end else begin
        ticks = $urandom_range(24);
      end
      play_row(p1, p2, drum, fx, ticks);
      stim_count += ticks + 1;
    end

    // drain
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ptds_pkg.sv
hw/rtl/ptds_div.sv
hw/rtl/ptds_ctrl.sv
hw/rtl/ptds_dp.sv
hw/rtl/two_channel_pulse_tone_drum_synth.sv
test/synth_sample_checker.sv
test/tb_top.sv
